@@ design/kwsc_pkg.sv @@
// ----------------------------------------------------------------------------
// kwsc_pkg: shared definitions for the keyword substitution cipher
// Operation codes, ASCII bounds, controller state and command/status types.
// ----------------------------------------------------------------------------
package kwsc_pkg;

    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_TEXT = 2'd2;

    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UZ = 8'h5A;
    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LZ = 8'h7A;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_FILL = 3'b100
    } kwsc_state_t;

    typedef struct packed {
        logic key_byte;
        logic text_take;
        logic fill_step;
        logic out_load;
    } kwsc_cmd_t;

    typedef struct packed {
        logic scan_last;
    } kwsc_sts_t;

endpackage

@@ design/kwsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// kwsc_ctrl: sequencing controller
// Decodes incoming transfers, runs the end-of-key fill walk and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module kwsc_ctrl
    import kwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic [1:0] operation,
    output logic       s_tready,
    input  logic       m_tready,
    output logic       m_tvalid,
    input  kwsc_sts_t  sts,
    output kwsc_cmd_t  cmd
);

    kwsc_state_t state_reg;
    kwsc_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (operation)
                        OP_KEY:  cmd.key_byte = 1'b1;
                        OP_END:  state_next = ST_FILL;
                        OP_TEXT:
                        begin
                            cmd.text_take = 1'b1;
                            state_next    = ST_LOOK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOOK:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.scan_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ design/kwsc_datapath.sv @@
// ----------------------------------------------------------------------------
// kwsc_datapath: substitution tables and key state
// Holds the forward and inverse tables, used-letter mask, fill position,
// fill scan counter, direction register and the output byte register.
// ----------------------------------------------------------------------------
module kwsc_datapath
    import kwsc_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  kwsc_cmd_t  cmd,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic [7:0] data_byte,
    output logic [7:0] out_byte,
    output kwsc_sts_t  sts
);

    localparam int LW = $clog2(ALPHABET_SIZE);
    localparam int CW = $clog2(ALPHABET_SIZE + 1);

    logic                     direction_reg;
    logic [ALPHABET_SIZE-1:0] used_reg;
    logic [ALPHABET_SIZE-1:0] used_base;
    logic [ALPHABET_SIZE-1:0] used_next;
    logic [CW-1:0]            fill_reg;
    logic [CW-1:0]            fill_base;
    logic [CW-1:0]            fill_next;
    logic                     key_ready_reg;
    logic                     key_ready_next;
    logic [LW-1:0]            scan_reg;
    logic [LW-1:0]            scan_next;

    logic [LW-1:0] fwd_mem [ALPHABET_SIZE];
    logic [LW-1:0] inv_mem [ALPHABET_SIZE];

    logic [7:0]    byte_reg;
    logic          lower_reg;
    logic          map_reg;
    logic          dir_sel_reg;
    logic [LW-1:0] fwd_rd_reg;
    logic [LW-1:0] inv_rd_reg;
    logic [7:0]    out_byte_reg;

    logic          is_upper;
    logic          is_lower;
    logic [7:0]    offset;
    logic          is_letter;
    logic [LW-1:0] letter_idx;
    logic [LW-1:0] app_idx;
    logic          app_req;
    logic          app_hit;
    logic          clear_key;
    logic [LW-1:0] sel;

    assign is_upper   = (data_byte >= CHAR_UA) && (data_byte <= CHAR_UZ);
    assign is_lower   = (data_byte >= CHAR_LA) && (data_byte <= CHAR_LZ);
    assign offset     = is_lower ? (data_byte - CHAR_LA) : (data_byte - CHAR_UA);
    assign is_letter  = (is_upper || is_lower) && (offset < 8'(ALPHABET_SIZE));
    assign letter_idx = is_letter ? offset[LW-1:0] : '0;

    assign sts.scan_last = (scan_reg == LW'(ALPHABET_SIZE - 1));

    // a key byte after a finished key starts a fresh key
    assign clear_key = cmd.key_byte && key_ready_reg;
    assign used_base = clear_key ? '0 : used_reg;
    assign fill_base = clear_key ? '0 : fill_reg;

    assign app_idx = cmd.fill_step ? scan_reg : letter_idx;
    assign app_req = (cmd.key_byte && is_letter) || cmd.fill_step;
    assign app_hit = app_req && !used_base[app_idx];

    always_comb
    begin
        used_next = used_base;
        if (app_hit)
            used_next[app_idx] = 1'b1;
        fill_next = fill_base + CW'(app_hit);

        key_ready_next = key_ready_reg;
        if (cmd.key_byte)
            key_ready_next = 1'b0;
        else if (cmd.fill_step && sts.scan_last)
            key_ready_next = 1'b1;

        scan_next = scan_reg;
        if (cmd.fill_step)
            scan_next = sts.scan_last ? '0 : scan_reg + LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            used_reg      <= '0;
            fill_reg      <= '0;
            key_ready_reg <= 1'b0;
            scan_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                direction_reg <= cfg_wr_data;
            used_reg      <= used_next;
            fill_reg      <= fill_next;
            key_ready_reg <= key_ready_next;
            scan_reg      <= scan_next;
        end
    end

    // table writes: append a letter at the fill position
    always_ff @(posedge clk)
    begin
        if (app_hit)
        begin
            fwd_mem[fill_base[LW-1:0]] <= app_idx;
            inv_mem[app_idx]           <= fill_base[LW-1:0];
        end
    end

    // registered table reads and text capture
    always_ff @(posedge clk)
    begin
        if (cmd.text_take)
        begin
            fwd_rd_reg  <= fwd_mem[letter_idx];
            inv_rd_reg  <= inv_mem[letter_idx];
            byte_reg    <= data_byte;
            lower_reg   <= is_lower;
            map_reg     <= is_letter && key_ready_reg;
            dir_sel_reg <= direction_reg;
        end
    end

    assign sel = dir_sel_reg ? inv_rd_reg : fwd_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_byte_reg <= map_reg ? ((lower_reg ? CHAR_LA : CHAR_UA) + 8'(sel))
                                    : byte_reg;
    end

    assign out_byte = out_byte_reg;

endmodule

@@ design/keyword_substitution_cipher.sv @@
// ----------------------------------------------------------------------------
// keyword_substitution_cipher: keyword substitution cipher engine
// Builds a keyword alphabet from a byte stream, then enciphers or deciphers
// text bytes through it, keeping letter case.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_tuser carries the operation (key byte, end of key, text
//   byte), s_tdata the ASCII byte. Output stream: m_tdata carries one byte
//   per text transfer; key and end-of-key transfers produce nothing.
//   cfg_wr_en/cfg_wr_data write the direction bit (0 encipher, 1 decipher)
//   while the block is idle.
// Sequence:
//   Key byte: taken while idle. End of key: the fill walk checks one letter
//   per cycle and appends it if unused, through the single table write
//   port; input is held off until the walk ends. Text byte: a registered
//   table read, then a load of the output register once that register is free.
// Reset: clears the used-letter mask, fill position, key-ready flag,
//   direction and output valid; table contents are only meaningful once a
//   key has been completed.
// Stall: a waiting result sits in the output register; key transfers keep
//   flowing, and the next text byte holds in lookup until the result drains.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher
    import kwsc_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  logic [1:0] s_tuser,     // [1:0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data  // direction
);

    kwsc_cmd_t cmd;
    kwsc_sts_t sts;

    // sequencing: decode transfers, walk the fill, drive output valid
    kwsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .operation (s_tuser),
        .s_tready  (s_tready),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // tables, key state and the output byte register
    kwsc_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .data_byte   (s_tdata),
        .out_byte    (m_tdata),
        .sts         (sts)
    );

    // no input transfer while the fill walk runs
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_step |-> !s_tready)
        else $error("input accepted during key fill");

    // a text transfer always moves into lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_TEXT)) |=> !s_tready)
        else $error("text transfer did not enter lookup");

    // never overwrite a result that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

endmodule

@@ bench/cipher_checker.sv @@
// ----------------------------------------------------------------------------
// cipher_checker: output checker for the keyword substitution cipher
// Watches the input, output and configuration ports, keeps its own copy of
// the keyword alphabet and compares every output byte with the expected one.
// ----------------------------------------------------------------------------
module cipher_checker
    import kwsc_pkg::*;
#(
    parameter int ALPHABET = 26
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  logic [1:0] s_tuser,     // [1:0] operation
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,     // [7:0] out_byte
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data, // direction
    output int         errors,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [4:0]          fwd_map [ALPHABET];
    logic [4:0]          inv_map [ALPHABET];
    logic [ALPHABET-1:0] used_mask;
    logic [4:0]          fill_pos;
    bit                  key_done;
    bit                  decipher;

    logic [7:0] expected_bytes [$];
    int         fail_count  = 0;
    int         outstanding = 0;

    assign errors  = fail_count;
    assign pending = outstanding;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Map an ASCII byte to its alphabet slot; zero return for non-letters.
    function automatic bit letter_slot(input logic [7:0] b, output logic [4:0] idx,
                                       output bit lower);
        lower = 1'b0;
        idx   = '0;
        if (b >= CHAR_UA && b <= CHAR_UZ && (b - CHAR_UA) < ALPHABET) begin
            idx = 5'(b - CHAR_UA);
            return 1'b1;
        end
        if (b >= CHAR_LA && b <= CHAR_LZ && (b - CHAR_LA) < ALPHABET) begin
            idx   = 5'(b - CHAR_LA);
            lower = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void take_letter(input logic [4:0] idx);
        if (used_mask[idx])
            return;
        used_mask[idx]    = 1'b1;
        fwd_map[fill_pos] = idx;
        inv_map[idx]      = fill_pos;
        fill_pos          = fill_pos + 5'd1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [4:0] idx;
        logic [4:0] slot;
        logic [7:0] mapped;
        logic [7:0] want;
        bit         lower;
        if (!rst_n)
        begin
            used_mask   = '0;
            fill_pos    = '0;
            key_done    = 1'b0;
            decipher    = 1'b0;
            outstanding = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_wr_en)
                decipher = cfg_wr_data;

            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    OP_KEY:
                    begin
                        if (key_done)
                        begin
                            key_done  = 1'b0;
                            used_mask = '0;
                            fill_pos  = '0;
                        end
                        if (letter_slot(s_tdata, idx, lower))
                            take_letter(idx);
                    end
                    OP_END:
                    begin
                        for (int n = 0; n < ALPHABET; n++)
                            take_letter(5'(n));
                        key_done = 1'b1;
                    end
                    OP_TEXT:
                    begin
                        mapped = s_tdata;
                        if (key_done && letter_slot(s_tdata, idx, lower))
                        begin
                            slot   = decipher ? inv_map[idx] : fwd_map[idx];
                            mapped = (lower ? CHAR_LA : CHAR_UA) + 8'(slot);
                        end
                        expected_bytes.push_back(mapped);
                        outstanding++;
                    end
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch($sformatf("out_byte 0x%02h with nothing expected", m_tdata));
                else
                begin
                    want = expected_bytes.pop_front();
                    outstanding--;
                    if (m_tdata !== want)
                        report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                                  m_tdata, want));
                end
            end
        end
    end

endmodule

@@ bench/tb_keyword_substitution_cipher.sv @@
// ----------------------------------------------------------------------------
// tb_keyword_substitution_cipher: stimulus and verdict for the cipher engine
// Drives a directed opening and then random keyword/text sequences through
// both directions under several idle and stall patterns; a separate checker
// predicts and compares every output byte.
// ----------------------------------------------------------------------------
module tb_keyword_substitution_cipher;
    import kwsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation code the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int ALPHABET      = 26;
    localparam int SETTLE_CYCLES = 40;   // room for an end-of-key fill walk to finish
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 200;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = '0;   // [7:0] data_byte
    logic [1:0] s_tuser     = '0;   // [1:0] operation
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0; // direction

    int errors;
    int pending;

    // Idle pattern, in percent of cycles.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Bump to ask the receiver for one long hold-off.
    int hold_requests  = 0;

    keyword_substitution_cipher #(
        .ALPHABET_SIZE (ALPHABET)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    cipher_checker #(
        .ALPHABET (ALPHABET)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Give up long after the slowest correct run would have finished.
    initial
    begin
        #10_000_000;
        $display("keyword_substitution_cipher test failed");
        $finish;
    end

    // Receiver: stall at the current rate, or hold off for a long stretch when
    // asked, counting the cycles here so the sender keeps going meanwhile.
    initial
    begin
        int served;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != served)
            begin
                served = hold_requests;
                m_tready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item and return at the edge where the transfer happens.
    // Ready is sampled at the falling edge, when everything has settled.
    task automatic send_item(input logic [1:0] op, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    // Drop valid and wait until every expected byte is back, then let the
    // block finish any fill walk that produces no output.
    task automatic hold_sender(input int settle);
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_direction(input logic dir);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? CHAR_LA : CHAR_UA;
        return base + 8'($urandom_range(ALPHABET - 1));
    endfunction

    // Mostly letters, else any byte at all.
    function automatic logic [7:0] pick_byte(input int letter_pct);
        if ($urandom_range(99) < letter_pct)
            return pick_letter();
        return 8'($urandom);
    endfunction

    // Extremes of both fields, every operation and the corner cases around
    // key completion: text before a key, repeated and non-letter key bytes,
    // a second end of key, and a key byte that restarts a finished key.
    task automatic run_directed();
        send_item(OP_TEXT, CHAR_UA);
        send_item(OP_TEXT, 8'h00);
        send_item(OP_KEY, CHAR_LZ);
        send_item(OP_KEY, 8'h45);
        send_item(OP_KEY, 8'h21);
        send_item(OP_KEY, CHAR_LZ);
        send_item(OP_KEY, 8'hFF);
        send_item(OP_UNUSED, CHAR_UZ);
        send_item(OP_END, 8'h00);
        send_item(OP_END, 8'hFF);
        send_item(OP_TEXT, CHAR_UA);
        send_item(OP_TEXT, CHAR_LZ);
        send_item(OP_TEXT, CHAR_LA);
        send_item(OP_TEXT, CHAR_UZ);
        send_item(OP_TEXT, CHAR_UA - 8'd1);
        send_item(OP_TEXT, CHAR_UZ + 8'd1);
        send_item(OP_TEXT, CHAR_LA - 8'd1);
        send_item(OP_TEXT, CHAR_LZ + 8'd1);
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_KEY, 8'h51);
        send_item(OP_TEXT, 8'h71);
        send_item(OP_END, 8'h00);
        send_item(OP_TEXT, 8'h6D);
    endtask

    // Mostly whole sequences: a fresh key, its end, then a run of text.
    // Sprinkle in noise: text before the key is done, doubled ends, unused
    // operations, and runs of text that reuse the key already loaded.
    task automatic run_phase(input int n_items, input bit with_hold, input bit with_pause);
        int  sent;
        int  key_len;
        int  text_len;
        bit  held;
        bit  paused;
        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 75)
            begin
                // Now and then a key long enough to use up the alphabet.
                key_len = ($urandom_range(9) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(0, 10);
                for (int k = 0; k < key_len; k++)
                begin
                    send_item(OP_KEY, pick_byte(85));
                    sent++;
                end
                if ($urandom_range(9) == 0)
                begin
                    send_item(OP_TEXT, pick_byte(70));
                    sent++;
                end
                send_item(OP_END, 8'($urandom));
                sent++;
                if ($urandom_range(14) == 0)
                begin
                    send_item(OP_END, 8'($urandom));
                    sent++;
                end
            end

            text_len = $urandom_range(4, 30);
            if (with_hold && !held && sent > n_items / 3)
            begin
                // Long receiver hold-off while a long text run keeps coming.
                held     = 1'b1;
                text_len = 60;
                hold_requests <= hold_requests + 1;
            end
            for (int t = 0; t < text_len; t++)
            begin
                send_item(OP_TEXT, pick_byte(75));
                sent++;
            end

            if ($urandom_range(19) == 0)
                send_item(OP_UNUSED, 8'($urandom));

            if (with_pause && !paused && sent > n_items / 2)
            begin
                paused = 1'b1;
                hold_sender(0);
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_direction(1'b0);
        run_directed();

        // Alternate direction; walk the idle patterns: none, sender idle,
        // receiver stalling, both.
        for (int p = 0; p < 8; p++)
        begin
            hold_sender(SETTLE_CYCLES);
            write_direction(p[0]);
            case (p / 2)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            run_phase(PHASE_ITEMS, p == 1, p == 4);
        end

        hold_sender(SETTLE_CYCLES);
        @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("keyword_substitution_cipher test passed");
        else
            $display("keyword_substitution_cipher test failed");
        $finish;
    end

endmodule
